// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked outside reset only.
`define ASSERT_NORST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/ctm_pkg.sv -----
// Shared constants and types of the census transform block.
package ctm_pkg;

  // Window geometry and frame limits
  localparam int WIN_R     = 3;
  localparam int WIN_C     = 4;
  localparam int MAX_WIDTH = 1024;
  localparam int ROW_LIMIT = 4096;
  localparam int WROWS     = 2 * WIN_R + 1;
  localparam int WCOLS     = 2 * WIN_C + 1;
  localparam int NPIX      = WROWS * WCOLS;

  // Field and register widths
  localparam int PIX_W    = 8;
  localparam int CODE_W   = 63;
  localparam int TDATA_W  = ((CODE_W + 7) / 8) * 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = 12;
  localparam int STORE_W  = PIX_W * 2 * WIN_R;

  // 5x5 mean: sum / 25 by reciprocal multiply
  localparam int MEAN_N      = 5;
  localparam int MEAN_DIV    = MEAN_N * MEAN_N;
  localparam int ROWSUM_W    = 11;
  localparam int SUM_W       = 13;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = (2 ** RECIP_SHIFT + MEAN_DIV - 1) / MEAN_DIV;
  localparam int RECIP_W     = 13;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Window: [row][column][bit], row 0 is the top row
  typedef logic [WROWS-1:0][WCOLS-1:0][PIX_W-1:0] window_t;

  // One beat from front to back: a full window and its end-of-frame mark
  typedef struct packed {
    window_t win;
    logic    last;
  } win_beat_t;

endpackage

// ----- rtl/ctm_front.sv -----
// Front: position counters, line store, window shift and interior classification.
module ctm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ctm_pkg::WIDTH_W-1:0]  image_width,
  input  logic [ctm_pkg::HEIGHT_W-1:0] image_height,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ctm_pkg::PIX_W-1:0]    pixel,
  input  logic                         frame_start,
  output logic                         beat_valid,
  input  logic                         beat_ready,
  output ctm_pkg::win_beat_t           beat
);
  import ctm_pkg::*;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic                col_end;
  logic                row_end;
  logic                accept;

  // Stage register: pixel waiting for its line store data
  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pixel;
  logic [COL_W-1:0]    s1_col;
  logic                s1_interior;
  logic                s1_last;
  logic                s1_adv;

  // Line store and write bypass
  logic [STORE_W-1:0]  line_mem [MAX_WIDTH];
  logic [STORE_W-1:0]  rd_data;
  logic                byp_valid;
  logic [COL_W-1:0]    byp_col;
  logic [STORE_W-1:0]  byp_data;
  logic [STORE_W-1:0]  stored;
  logic [STORE_W-1:0]  store_new;

  window_t             win;
  window_t             win_next;

  // Effective frame size, saturated
  assign eff_w = (int'(image_width) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : image_width;
  assign eff_h = (int'(image_height) > ROW_LIMIT) ? HEIGHT_W'(ROW_LIMIT) : image_height;

  // Position of the incoming pixel
  assign col     = frame_start ? '0 : column_count;
  assign row     = frame_start ? '0 : row_count;
  assign col_end = (int'(col) + 1) >= int'(eff_w);
  assign row_end = (int'(row) + 1) >= int'(eff_h);

  assign s1_adv   = s1_valid && (!s1_interior || beat_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : ROW_W'(row + 1'b1);
      end else begin
        column_count <= COL_W'(col + 1'b1);
        row_count    <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pixel;
      s1_col      <= col;
      s1_interior <= (int'(row) >= 2 * WIN_R) && (int'(col) >= 2 * WIN_C);
      s1_last     <= row_end && col_end;
    end
  end

  // Line store: read on accept, write back when the pixel leaves the stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= store_new;
    end
  end

  // Most recent write, covers a read issued on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (s1_adv) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byp_col  <= s1_col;
      byp_data <= store_new;
    end
  end

  assign stored    = (byp_valid && (byp_col == s1_col)) ? byp_data : rd_data;
  assign store_new = {stored[STORE_W-PIX_W-1:0], s1_pixel};

  // Shift left, new column on the right: older rows from the store, bottom is the pixel
  always_comb begin
    for (int i = 0; i < WROWS; i++) begin
      for (int j = 0; j < WCOLS - 1; j++) begin
        win_next[i][j] = win[i][j+1];
      end
    end
    for (int i = 0; i < WROWS - 1; i++) begin
      win_next[i][WCOLS-1] = stored[PIX_W*(2*WIN_R-1-i) +: PIX_W];
    end
    win_next[WROWS-1][WCOLS-1] = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win <= win_next;
    end
  end

  assign beat_valid = s1_valid && s1_interior;
  assign beat.win   = win_next;
  assign beat.last  = s1_last;

endmodule

// ----- rtl/ctm_queue.sv -----
// Two-entry queue of window beats between front and back.
module ctm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  ctm_pkg::win_beat_t push_beat,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ctm_pkg::win_beat_t pop_beat
);
  import ctm_pkg::*;

  win_beat_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (int'(count) != QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_beat   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'((int'(wr_ptr) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'((int'(rd_ptr) + 1) % QUEUE_DEPTH);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

endmodule

// ----- rtl/ctm_back.sv -----
// Back: 5x5 sum, mean by reciprocal multiply, window compare, output register.
module ctm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       beat_valid,
  output logic                       beat_ready,
  input  ctm_pkg::win_beat_t         beat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ctm_pkg::CODE_W-1:0] census_code,
  output logic                       last_of_frame
);
  import ctm_pkg::*;

  // Stage 1: row sums
  logic                      v1;
  window_t                   w1;
  logic                      last1;
  logic [ROWSUM_W-1:0]       rs1   [MEAN_N];
  logic [ROWSUM_W-1:0]       rs_c  [MEAN_N];
  // Stage 2: total
  logic                      v2;
  window_t                   w2;
  logic                      last2;
  logic [SUM_W-1:0]          total2;
  logic [SUM_W-1:0]          total_c;
  // Stage 3: mean
  logic                      v3;
  window_t                   w3;
  logic                      last3;
  logic [PIX_W-1:0]          mean3;
  logic [SUM_W+RECIP_W-1:0]  prod_c;
  logic [CODE_W-1:0]         code_c;

  logic load1, load2, load3, load_o;

  // Elastic pipeline: a stage loads when empty or when it empties this cycle
  assign load_o     = !out_valid || out_ready;
  assign load3      = !v3 || load_o;
  assign load2      = !v2 || load3;
  assign load1      = !v1 || load2;
  assign beat_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1)  v1        <= beat_valid;
      if (load2)  v2        <= v1;
      if (load3)  v3        <= v2;
      if (load_o) out_valid <= v3;
    end
  end

  always_comb begin
    for (int r = 0; r < MEAN_N; r++) begin
      rs_c[r] = '0;
      for (int c = 0; c < MEAN_N; c++) begin
        rs_c[r] = rs_c[r] + ROWSUM_W'(beat.win[WIN_R-2+r][WIN_C-2+c]);
      end
    end
  end

  always_comb begin
    total_c = '0;
    for (int r = 0; r < MEAN_N; r++) begin
      total_c = total_c + SUM_W'(rs1[r]);
    end
  end

  // floor(sum / 25) exact for sums up to 25 * 255
  assign prod_c = total2 * RECIP_W'(RECIP);

  // Raster order from the top-left, top-left in the highest used bit
  always_comb begin
    code_c = '0;
    for (int i = 0; i < WROWS; i++) begin
      for (int j = 0; j < WCOLS; j++) begin
        code_c[NPIX-1-(i*WCOLS+j)] = (w3[i][j] < mean3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      w1    <= beat.win;
      last1 <= beat.last;
      rs1   <= rs_c;
    end
    if (load2) begin
      w2     <= w1;
      last2  <= last1;
      total2 <= total_c;
    end
    if (load3) begin
      w3    <= w2;
      last3 <= last2;
      mean3 <= prod_c[RECIP_SHIFT +: PIX_W];
    end
    if (load_o) begin
      census_code   <= code_c;
      last_of_frame <= last3;
    end
  end

endmodule

// ----- rtl/census_transform_mean_ref.sv -----
// Census transform top: 7x9 window codes against the 5x5 mean, one pixel per clock unless stalled.
// Interior pixel path: front stage register, queue, row-sum, total and mean stages, output register.
// Throughput: one pixel per cycle unless the code stream stalls; the line store takes one read and one write per pixel.
// Reset (rst, synchronous): position counters, pipeline valids and queue cleared,
// frame size back to 640 x 480; the line store is not cleared and needs no clearing pass.
module census_transform_mean_ref (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [ctm_pkg::CFG_W-1:0]    cfg_data,
  // pixel stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ctm_pkg::PIX_W-1:0]    s_axis_tdata,   // [7:0] pixel
  input  logic                         s_axis_tuser,   // [0] frame_start
  // census code stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ctm_pkg::TDATA_W-1:0]  m_axis_tdata,   // [62:0] census_code, [63] zero
  output logic                         m_axis_tlast    // last_of_frame
);
  import ctm_pkg::*;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  win_beat_t           front_beat;
  logic                front_valid;
  logic                front_ready;
  win_beat_t           back_beat;
  logic                back_valid;
  logic                back_ready;
  logic [CODE_W-1:0]   census_code;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(640);
      image_height <= HEIGHT_W'(480);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  ctm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .pixel        (s_axis_tdata),
    .frame_start  (s_axis_tuser),
    .beat_valid   (front_valid),
    .beat_ready   (front_ready),
    .beat         (front_beat)
  );

  ctm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_beat  (front_beat),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_beat   (back_beat)
  );

  ctm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .beat_valid    (back_valid),
    .beat_ready    (back_ready),
    .beat          (back_beat),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .census_code   (census_code),
    .last_of_frame (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_W-CODE_W)'(0), census_code};

endmodule

// ----- rtl/ctm_checker.sv -----
// Port-level checks of the census transform top, bound to it.
`include "assert_macros.svh"

module ctm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ctm_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic                         m_axis_tlast
);

  // A stalled code beat keeps its data and end-of-frame mark
  `ASSERT_NORST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")

  // Reset empties the output register
  `ASSERT_ALWAYS(a_rst_out_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // Reset leaves the front stage free to take a pixel
  `ASSERT_ALWAYS(a_rst_in_ready, clk, rst |=> s_axis_tready, "input not ready after reset")

endmodule

bind census_transform_mean_ref ctm_checker u_ctm_checker (.*);
